// ===== hdl/primitive_triangle_assembler_defines.svh =====
// ---------------------------------------------------------------------------
// primitive triangle assembler assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef PRIMITIVE_TRIANGLE_ASSEMBLER_DEFINES_SVH
`define PRIMITIVE_TRIANGLE_ASSEMBLER_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge
`define PTA_ASSERT(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pta assertion failed");
// antecedent at one edge implies consequent at the next
`define PTA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pta assertion failed");
`else
`define PTA_ASSERT(name, cond)
`define PTA_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== hdl/pta_pkg.sv =====
// ---------------------------------------------------------------------------
// pta_pkg
// shared types, codes and helpers of the primitive triangle assembler
// ---------------------------------------------------------------------------
`default_nettype none

package pta_pkg;

  localparam int INDEX_WIDTH = 32;
  localparam logic [31:0] IDX_MASK = 32'hFFFF_FFFF >> (32 - INDEX_WIDTH);

  // primitive modes
  localparam logic [2:0] MODE_TRIANGLES  = 3'd0;
  localparam logic [2:0] MODE_STRIP      = 3'd1;
  localparam logic [2:0] MODE_FAN        = 3'd2;
  localparam logic [2:0] MODE_POLYGON    = 3'd3;
  localparam logic [2:0] MODE_QUADS      = 3'd4;
  localparam logic [2:0] MODE_QUAD_STRIP = 3'd5;

  // normal binding codes
  localparam logic [1:0] BIND_OVERALL   = 2'd0;
  localparam logic [1:0] BIND_PER_SET   = 2'd1;
  localparam logic [1:0] BIND_PER_PRIM  = 2'd2;
  localparam logic [1:0] BIND_PER_CORNER = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_NORMAL_BINDING = 2'd0;
  localparam logic [1:0] CFG_SECTION_ID     = 2'd1;

  typedef struct packed {
    logic [2:0]  prim_mode;
    logic [31:0] vertex_index;
    logic        first_in_set;
    logic        last_in_set;
  } pta_in_t;

  typedef struct packed {
    logic [31:0] corner_a;
    logic [31:0] corner_b;
    logic [31:0] corner_c;
    logic [31:0] normal_a;
    logic [31:0] normal_b;
    logic [31:0] normal_c;
    logic [31:0] section_out;
    logic        run_end;
  } pta_out_t;

  // up to two triangles produced by one vertex
  typedef struct packed {
    logic [1:0] cnt;
    pta_out_t   tri_first;
    pta_out_t   tri_second;
  } pta_push_t;

  function automatic pta_out_t pta_make_tri(
    input logic [31:0] a,
    input logic [31:0] b,
    input logic [31:0] c,
    input logic [31:0] nc,
    input logic [1:0]  bind_mode,
    input logic [31:0] sec,
    input logic        re
  );
    pta_out_t t;
    t.corner_a    = a;
    t.corner_b    = b;
    t.corner_c    = c;
    t.normal_a    = (bind_mode == BIND_PER_CORNER) ? a : nc;
    t.normal_b    = (bind_mode == BIND_PER_CORNER) ? b : nc;
    t.normal_c    = (bind_mode == BIND_PER_CORNER) ? c : nc;
    t.section_out = sec;
    t.run_end     = re;
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pta_core.sv =====
// ---------------------------------------------------------------------------
// pta_core
// vertex history, set position, normal counter and triangle selection
// ---------------------------------------------------------------------------
`default_nettype none
`include "primitive_triangle_assembler_defines.svh"

module pta_core import pta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire pta_in_t     item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_wdata,
  output pta_push_t        push
);

  logic [1:0]  binding_r;
  logic [31:0] section_r;
  logic [31:0] pivot_r, pivot_nxt;
  logic [31:0] p1_r, p2_r, p3_r;
  logic [1:0]  pos_r, pos_nxt;
  logic [31:0] nc_r, nc_nxt;

  logic [31:0] v, piv;
  logic [1:0]  k;
  logic [1:0]  n;
  logic        inc;
  logic [31:0] a0, b0, c0, a1, b1, c1;

  always_comb begin
    v   = item.vertex_index & IDX_MASK;
    k   = item.first_in_set ? 2'd0 : pos_r;
    piv = item.first_in_set ? v : pivot_r;
    pivot_nxt = piv;
    n   = 2'd0;
    inc = 1'b0;
    a0 = p2_r; b0 = p1_r; c0 = v;
    a1 = p3_r; b1 = p1_r; c1 = v;
    pos_nxt = (k == 2'd3) ? 2'd2 : k + 2'd1;
    unique case (item.prim_mode)
      MODE_TRIANGLES: begin
        if (k == 2'd2) begin
          n = 2'd1;
          inc = (binding_r == BIND_PER_PRIM);
        end
        pos_nxt = (k >= 2'd2) ? 2'd0 : k + 2'd1;
      end
      MODE_STRIP: begin
        if (k >= 2'd2) begin
          n = 2'd1;
          // odd position flips winding
          if (k[0]) begin
            b0 = v; c0 = p1_r;
          end
        end
      end
      MODE_FAN, MODE_POLYGON: begin
        if (k >= 2'd2) begin
          n = 2'd1;
          a0 = piv;
        end
      end
      MODE_QUADS: begin
        if (k == 2'd3) begin
          n = 2'd2;
          a0 = p3_r; b0 = p2_r; c0 = p1_r;
          inc = (binding_r == BIND_PER_PRIM);
        end
        pos_nxt = k + 2'd1;
      end
      MODE_QUAD_STRIP: begin
        if (k == 2'd3) begin
          n = 2'd2;
          a0 = p3_r; b0 = p2_r; c0 = p1_r;
          a1 = p2_r; b1 = v;    c1 = p1_r;
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase
    if (item.last_in_set) begin
      if (binding_r == BIND_PER_SET) inc = 1'b1;
      if (binding_r == BIND_PER_PRIM && item.prim_mode != MODE_TRIANGLES &&
          item.prim_mode != MODE_QUADS && item.prim_mode <= MODE_QUAD_STRIP) begin
        inc = 1'b1;
      end
    end
    nc_nxt = nc_r + {31'd0, inc};
  end

  always_comb begin
    push.cnt        = acc ? n : 2'd0;
    push.tri_first  = pta_make_tri(a0, b0, c0, nc_r, binding_r, section_r, n == 2'd1);
    push.tri_second = pta_make_tri(a1, b1, c1, nc_r, binding_r, section_r, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binding_r <= BIND_OVERALL;
      section_r <= '0;
      pivot_r   <= '0;
      p1_r      <= '0;
      p2_r      <= '0;
      p3_r      <= '0;
      pos_r     <= '0;
      nc_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_NORMAL_BINDING: binding_r <= cfg_wdata[1:0];
          CFG_SECTION_ID:     section_r <= cfg_wdata;
          default:            ;
        endcase
      end
      if (acc) begin
        pivot_r <= pivot_nxt;
        p3_r    <= p2_r;
        p2_r    <= p1_r;
        p1_r    <= v;
        pos_r   <= pos_nxt;
        nc_r    <= nc_nxt;
      end
    end
  end

  `PTA_ASSERT_NEXT(a_nc_hold, !acc, $stable(nc_r))
  `PTA_ASSERT_NEXT(a_pos_hold, !acc && !cfg_we, $stable(pos_r) && $stable(p1_r))
  `PTA_ASSERT(a_pair_quad, push.cnt != 2'd2 ||
    item.prim_mode == MODE_QUADS || item.prim_mode == MODE_QUAD_STRIP)

endmodule

`default_nettype wire

// ===== hdl/pta_queue.sv =====
// ---------------------------------------------------------------------------
// pta_queue
// four-entry triangle queue, two writes and one read per cycle
// ---------------------------------------------------------------------------
`default_nettype none
`include "primitive_triangle_assembler_defines.svh"

module pta_queue import pta_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pta_push_t push,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_ready,
  output pta_out_t       out_data
);

  pta_out_t   entry_r [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  always_comb begin
    room      = (cnt_r <= 3'd2);
    out_valid = (cnt_r != 3'd0);
    out_data  = entry_r[rp_r];
    pop       = out_valid && out_ready;
    wp_nxt    = wp_r + push.cnt;
    rp_nxt    = rp_r + {1'b0, pop};
    cnt_nxt   = cnt_r + {1'b0, push.cnt} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      entry_r[wp_r] <= push.tri_first;
    end
    if (push.cnt == 2'd2) begin
      entry_r[wp_r + 2'd1] <= push.tri_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `PTA_ASSERT(a_cnt_max, cnt_r <= 3'd4)
  `PTA_ASSERT_NEXT(a_push_shows, cnt_r == 3'd0 && push.cnt != 2'd0, out_valid)

endmodule

`default_nettype wire

// ===== hdl/primitive_triangle_assembler.sv =====
// a vertex's triangles are registered in the queue behind any already waiting
// throughput: one vertex per cycle; a quad vertex queues two triangles, drained one a cycle
// input stalls only when the four-entry triangle queue has fewer than two free slots
// reset: synchronous active-low rst_n clears history, counters, queue and config registers
// ---------------------------------------------------------------------------
// primitive_triangle_assembler
// turns a vertex index stream into triangle index triples with normals
// ---------------------------------------------------------------------------
`default_nettype none

module primitive_triangle_assembler import pta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // vertex input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire pta_in_t     in_data,
  // triangle result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output pta_out_t         out_data,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic      acc;
  logic      room;
  pta_push_t push;

  // config writes are always accepted; cfg_ready is tied high
  assign cfg_ready = 1'b1;

  // a vertex transaction needs space for the worst case of two triangles
  assign in_ready = room;
  assign acc      = in_valid && room;

  // assembly state and triangle selection
  pta_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (in_data),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .push      (push)
  );

  // result buffering separates the two handshakes
  pta_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
